@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the ordered list engine RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define OLE_ASSERT_RST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define OLE_ASSERT(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/ole_pkg.sv @@
// ---------------------------------------------------------------------------
// ole_pkg
// Sizes, command and status codes and the cell control word of the
// ordered list engine.
// ---------------------------------------------------------------------------
package ole_pkg;

  // List capacity and derived widths.
  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int ST_W      = 3;
  localparam int FPOS_W    = 4;
  localparam int ECNT_W    = 5;
  localparam int S_FIELD_W = CMD_W + 2 * DATA_W + POS_W;
  localparam int M_FIELD_W = ST_W + FPOS_W + DATA_W + ECNT_W;
  localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_FIND      = 3'd2,
    CMD_REPLACE   = 3'd3,
    CMD_REMOVE    = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  // Result status codes.
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Action broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_SHIFT_BACK = 3'd1,
    ACT_WRITE_AT   = 3'd2,
    ACT_SHIFT_FWD  = 3'd3,
    ACT_COMPARE    = 3'd4
  } cell_act_t;

  // Control word seen by all cells.
  typedef struct packed {
    cell_act_t               act;
    logic [IDX_W-1:0]        sel;
    logic [CNT_W-1:0]        count;
    logic [DATA_W-1:0]       key;
    logic [DATA_W-1:0]       wdata;
  } cell_ctl_t;

endpackage

@@ rtl/core/ole_cell.sv @@
// ---------------------------------------------------------------------------
// ole_cell
// One list slot: holds an entry, takes a word from either neighbor on a
// shift, and registers whether its entry matches the search key.
// ---------------------------------------------------------------------------
module ole_cell (
  input  logic                        clk,
  input  logic [ole_pkg::IDX_W-1:0]   idx,
  input  ole_pkg::cell_ctl_t          ctl,
  input  logic [ole_pkg::DATA_W-1:0]  prev_data,
  input  logic [ole_pkg::DATA_W-1:0]  next_data,
  output logic [ole_pkg::DATA_W-1:0]  data,
  output logic                        match
);
  import ole_pkg::*;

  // Entry update and key compare.
  always_ff @(posedge clk) begin
    case (ctl.act)
      ACT_SHIFT_BACK: begin
        data <= prev_data;
      end
      ACT_WRITE_AT: begin
        if (idx == ctl.sel) begin
          data <= ctl.wdata;
        end
      end
      ACT_SHIFT_FWD: begin
        if (idx >= ctl.sel) begin
          data <= next_data;
        end
      end
      ACT_COMPARE: begin
        match <= (data == ctl.key) && (CNT_W'(idx) < ctl.count);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/ordered_list_engine_core.sv @@
// ---------------------------------------------------------------------------
// ordered_list_engine_core
// Ordered list of up to DEPTH signed 32-bit entries held in a chain of
// cells, with insert, find, replace, remove and read commands.
// ---------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_ stream, one per word; each gives exactly
//   one result word on the m_ stream.
//   A command passes an accept step, a compare step in which every
//   cell compares its entry with the key and registers the match, and a
//   resolve step that resolves the first match, moves the cells and
//   loads the result register. The result shows on m_tvalid in the cycle
//   after the resolve step; a new command can be taken once it is done.
//   The chain shifts the entries in one step, so insert at front and
//   remove cost the same as any other command.
//   When the receiver stalls, the result register holds its word; one
//   more command is accepted and waits in its resolve step until the
//   result register is free.
//   Reset empties the list and drops any pending result. The entries
//   themselves are not cleared; only entries below the count are read.
// ---------------------------------------------------------------------------
module ordered_list_engine_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cmd[2:0], value[34:3], new_value[66:35], position[74:67], zero fill
  input  logic [ole_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status[2:0], found_position[6:3], read_value[38:7],
  // entry_count[43:39], zero fill
  output logic [ole_pkg::M_TDATA_W-1:0]  m_tdata
);
  import ole_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [CMD_W-1:0]       cmd_r;
  logic [DATA_W-1:0]      key_r;
  logic [DATA_W-1:0]      nval_r;
  logic [POS_W-1:0]       pos_r;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_next;
  cell_ctl_t              ctl;
  logic [DATA_W-1:0]      cell_data [DEPTH];
  logic [DATA_W-1:0]      cell_next [DEPTH];
  logic [DATA_W-1:0]      cell_prev [DEPTH];
  logic [DEPTH-1:0]       match_vec;
  logic [DEPTH-1:0]       first_oh;
  logic [IDX_W-1:0]       hit_idx;
  logic                   exec_fire;
  logic                   in_fire;
  logic                   list_empty;
  logic                   list_full;
  logic                   pos_bad;
  status_t                res_status;
  logic [FPOS_W-1:0]      res_fpos;
  logic [DATA_W-1:0]      res_rval;

  assign in_fire    = s_tvalid && s_tready;
  assign s_tready   = (state == S_IDLE);
  assign exec_fire  = (state == S_EXEC) && (!m_tvalid || m_tready);
  assign list_empty = (count == '0);
  assign list_full  = (count == CNT_W'(DEPTH));
  assign pos_bad    = (pos_r >= POS_W'(count));

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= s_tdata[CMD_W-1:0];
      key_r  <= s_tdata[CMD_W +: DATA_W];
      nval_r <= s_tdata[CMD_W + DATA_W +: DATA_W];
      pos_r  <= s_tdata[CMD_W + 2 * DATA_W +: POS_W];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // First match: isolate the lowest set bit, then encode it.
  assign first_oh = match_vec & (~match_vec + DEPTH'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_oh[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  // Result and cell action for the compare and resolve steps.
  always_comb begin
    ctl.act    = ACT_NONE;
    ctl.sel    = '0;
    ctl.count  = count;
    ctl.key    = key_r;
    ctl.wdata  = key_r;
    count_next = count;
    res_status = ST_OK;
    res_fpos   = '0;
    res_rval   = '0;
    if (state == S_CMP) begin
      ctl.act = ACT_COMPARE;
    end else if (exec_fire) begin
      case (cmd_r)
        CMD_INS_FRONT: begin
          if (list_full) begin
            res_status = ST_FULL;
          end else begin
            ctl.act    = ACT_SHIFT_BACK;
            count_next = count + CNT_W'(1);
          end
        end
        CMD_INS_BACK: begin
          if (list_full) begin
            res_status = ST_FULL;
          end else begin
            ctl.act    = ACT_WRITE_AT;
            ctl.sel    = count[IDX_W-1:0];
            count_next = count + CNT_W'(1);
          end
        end
        CMD_FIND, CMD_REPLACE: begin
          if (list_empty) begin
            res_status = ST_EMPTY;
          end else if (match_vec == '0) begin
            res_status = ST_NOT_FOUND;
          end else begin
            res_fpos = FPOS_W'(hit_idx);
            if (cmd_r == CMD_REPLACE) begin
              ctl.act   = ACT_WRITE_AT;
              ctl.sel   = hit_idx;
              ctl.wdata = nval_r;
            end
          end
        end
        CMD_REMOVE: begin
          if (list_empty) begin
            res_status = ST_EMPTY;
          end else if (pos_bad) begin
            res_status = ST_BAD_POS;
          end else begin
            ctl.act    = ACT_SHIFT_FWD;
            ctl.sel    = pos_r[IDX_W-1:0];
            count_next = count - CNT_W'(1);
          end
        end
        CMD_READ: begin
          if (list_empty) begin
            res_status = ST_EMPTY;
          end else if (pos_bad) begin
            res_status = ST_BAD_POS;
          end else begin
            res_rval = cell_data[pos_r[IDX_W-1:0]];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_tdata <= M_TDATA_W'({ECNT_W'(count_next), res_rval, res_fpos, res_status});
    end
  end

  // Chain of cells; cell 0 takes the new value on an insert at front.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_prev[i] = ctl.wdata;
    end else begin : g_mid
      assign cell_prev[i] = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign cell_next[i] = cell_data[i];
    end else begin : g_inner
      assign cell_next[i] = cell_data[i+1];
    end

    ole_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .prev_data (cell_prev[i]),
      .next_data (cell_next[i]),
      .data      (cell_data[i]),
      .match     (match_vec[i])
    );
  end

  // Checks.
  `OLE_ASSERT_RST(a_accept_to_cmp, clk, rst, in_fire |=> (state == S_CMP), "no compare step")
  `OLE_ASSERT_RST(a_count_only_on_exec, clk, rst, !exec_fire |=> $stable(count), "count moved")
  `OLE_ASSERT_RST(a_result_from_exec, clk, rst, $rose(m_tvalid) |-> $past(exec_fire), "no resolve")

endmodule
